/* rtl/pf2bgra_pkg.sv */
// Shared types, codes and the 5-to-8 bit expansion table for the BGRA8888 converter.
package pf2bgra_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_IDX_W       = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int BYTE_W          = 8;
    localparam int SLOT_CMP_W      = BYTE_W + 1;

    localparam logic [BYTE_W-1:0] CHAN_FULL = 8'hFF;
    localparam logic [BYTE_W-1:0] CHAN_ZERO = 8'h00;

    typedef enum logic [1:0] {
        FMT_BGRA32   = 2'd0,
        FMT_BGR24    = 2'd1,
        FMT_ARGB1555 = 2'd2,
        FMT_PAL8     = 2'd3
    } pixel_format_t;

    typedef enum logic {
        OP_CONVERT   = 1'b0,
        OP_PAL_WRITE = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] g;
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] a;
    } bgra_t;

    typedef struct packed {
        logic                 en;
        logic [PAL_IDX_W-1:0] slot;
        bgra_t                color;
    } pal_wr_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic [BYTE_W-1:0] byte2;
        logic [BYTE_W-1:0] byte3;
    } src_bytes_t;

    // True when an 8-bit index falls inside the palette.
    function automatic logic in_palette(input logic [BYTE_W-1:0] idx);
        logic [SLOT_CMP_W-1:0] wide_idx;
        wide_idx = {1'b0, idx};
        return wide_idx < SLOT_CMP_W'(PALETTE_ENTRIES);
    endfunction

    // floor(v * 255 / 31) for a 5-bit channel.
    function automatic logic [BYTE_W-1:0] expand5(input logic [4:0] v);
        logic [BYTE_W-1:0] res;
        case (v)
            5'd0:    res = 8'd0;
            5'd1:    res = 8'd8;
            5'd2:    res = 8'd16;
            5'd3:    res = 8'd24;
            5'd4:    res = 8'd32;
            5'd5:    res = 8'd41;
            5'd6:    res = 8'd49;
            5'd7:    res = 8'd57;
            5'd8:    res = 8'd65;
            5'd9:    res = 8'd74;
            5'd10:   res = 8'd82;
            5'd11:   res = 8'd90;
            5'd12:   res = 8'd98;
            5'd13:   res = 8'd106;
            5'd14:   res = 8'd115;
            5'd15:   res = 8'd123;
            5'd16:   res = 8'd131;
            5'd17:   res = 8'd139;
            5'd18:   res = 8'd148;
            5'd19:   res = 8'd156;
            5'd20:   res = 8'd164;
            5'd21:   res = 8'd172;
            5'd22:   res = 8'd180;
            5'd23:   res = 8'd189;
            5'd24:   res = 8'd197;
            5'd25:   res = 8'd205;
            5'd26:   res = 8'd213;
            5'd27:   res = 8'd222;
            5'd28:   res = 8'd230;
            5'd29:   res = 8'd238;
            5'd30:   res = 8'd246;
            5'd31:   res = 8'd255;
            default: res = 8'd0;
        endcase
        return res;
    endfunction

endpackage

/* rtl/pf2bgra_palette.sv */
// Palette memory with per-entry valid bits; unwritten entries read as zero.
module pf2bgra_palette
    import pf2bgra_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  pal_wr_t              wr,
    input  logic                 rd_en,
    input  logic [BYTE_W-1:0]    rd_index,
    output bgra_t                rd_color
);

    bgra_t                      pal_mem_reg [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] valid_reg;
    logic [PALETTE_ENTRIES-1:0] valid_next;
    bgra_t                      rd_data_reg;
    logic                       rd_hit_reg;
    logic                       rd_hit_next;
    logic [PAL_IDX_W-1:0]       rd_idx;

    assign rd_idx = rd_index[PAL_IDX_W-1:0];

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.slot] = 1'b1;
        end
    end

    always_comb
    begin
        rd_hit_next = rd_hit_reg;
        if (rd_en)
        begin
            rd_hit_next = in_palette(rd_index) && valid_reg[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            rd_hit_reg <= rd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            pal_mem_reg[wr.slot] <= wr.color;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= pal_mem_reg[rd_idx];
        end
    end

    // Mask entries that were never written or lie outside the palette.
    assign rd_color = rd_hit_reg ? rd_data_reg : bgra_t'('0);

endmodule

/* rtl/pf2bgra_unpack.sv */
// Per-format conversion of source bytes or a palette entry into BGRA8888.
module pf2bgra_unpack
    import pf2bgra_pkg::*;
(
    input  pixel_format_t fmt,
    input  src_bytes_t    src,
    input  bgra_t         pal_color,
    output bgra_t         color
);

    always_comb
    begin
        case (fmt)
            FMT_BGRA32:
            begin
                color.b = src.byte0;
                color.g = src.byte1;
                color.r = src.byte2;
                color.a = src.byte3;
            end
            FMT_BGR24:
            begin
                color.b = src.byte0;
                color.g = src.byte1;
                color.r = src.byte2;
                color.a = CHAN_FULL;
            end
            FMT_ARGB1555:
            begin
                color.b = expand5(src.byte0[4:0]);
                color.g = expand5({src.byte1[1:0], src.byte0[7:5]});
                color.r = expand5(src.byte1[6:2]);
                color.a = src.byte1[7] ? CHAN_FULL : CHAN_ZERO;
            end
            FMT_PAL8:
            begin
                color = pal_color;
            end
            default:
            begin
                color = '0;
            end
        endcase
    end

endmodule

/* rtl/pixel_format_to_bgra8888.sv */
// Top level of the pixel format converter to 8-bit blue, green, red, alpha.
//
// Converts one source pixel per input transaction into BGRA8888. The format
// register (cfg_wr_en / cfg_wr_data) selects 32-bit BGRA pass-through, 24-bit
// BGR with alpha forced to 255, little-endian ARGB1555 with each 5-bit
// channel expanded to floor(v*255/31), or an 8-bit index into a 256-entry
// BGRA palette. A palette-write transaction (opcode 1) stores one entry and
// produces no output. The block sustains one transaction per clock on both
// channels while the output is not stalled. The accept edge captures the
// pixel and reads the palette memory through its registered read port; the
// converted result is loaded into the output register once that register
// is free or drains. A palette write takes effect at its own accept
// edge, so a lookup accepted in the very next cycle already sees it. Every
// palette entry carries a valid bit cleared by reset, so entries read as zero
// until written and no clearing pass is needed after reset. Write the format
// register only while no pixel is in flight.
module pixel_format_to_bgra8888
    import pf2bgra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    // input channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    input  logic [BYTE_W-1:0] byte0,
    input  logic [BYTE_W-1:0] byte1,
    input  logic [BYTE_W-1:0] byte2,
    input  logic [BYTE_W-1:0] byte3,
    input  logic [BYTE_W-1:0] palette_slot,
    input  logic              last_pixel,
    // output channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] blue,
    output logic [BYTE_W-1:0] green,
    output logic [BYTE_W-1:0] red,
    output logic [BYTE_W-1:0] alpha,
    output logic              run_end
);

    pixel_format_t fmt_reg;
    pixel_format_t fmt_next;

    // capture stage
    logic          s1_valid_reg;
    logic          s1_valid_next;
    src_bytes_t    s1_bytes_reg;
    logic          s1_last_reg;

    // result stage
    logic          out_valid_reg;
    logic          out_valid_next;
    bgra_t         color_reg;
    logic          run_end_reg;

    logic          in_fire;
    logic          is_convert;
    logic          s1_advance;
    pal_wr_t       pal_wr;
    bgra_t         pal_color;
    bgra_t         conv_color;

    assign in_fire    = in_valid && in_ready;
    assign is_convert = (opcode == OP_CONVERT);

    // Advance the capture stage whenever the output register is free or drains.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // Format register: written directly, no handshake.
    always_comb
    begin
        fmt_next = fmt_reg;
        if (cfg_wr_en)
        begin
            fmt_next = pixel_format_t'(cfg_wr_data);
        end
    end

    // Palette writes drop out here; only converts enter the capture stage.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = is_convert;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= FMT_BGRA32;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fmt_reg       <= fmt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the capture stage: hold until the next accepted convert.
    always_ff @(posedge clk)
    begin
        if (in_fire && is_convert)
        begin
            s1_bytes_reg <= '{byte0: byte0, byte1: byte1, byte2: byte2, byte3: byte3};
            s1_last_reg  <= last_pixel;
        end
    end

    // Result payload: load on advance, hold while the sink stalls.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            color_reg   <= conv_color;
            run_end_reg <= s1_last_reg;
        end
    end

    // Slots beyond the palette are ignored.
    assign pal_wr.en    = in_fire && !is_convert && in_palette(palette_slot);
    assign pal_wr.slot  = palette_slot[PAL_IDX_W-1:0];
    assign pal_wr.color = '{b: byte0, g: byte1, r: byte2, a: byte3};

    pf2bgra_palette u_palette (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (pal_wr),
        .rd_en    (in_fire && is_convert),
        .rd_index (byte0),
        .rd_color (pal_color)
    );

    pf2bgra_unpack u_unpack (
        .fmt       (fmt_reg),
        .src       (s1_bytes_reg),
        .pal_color (pal_color),
        .color     (conv_color)
    );

    assign out_valid = out_valid_reg;
    assign blue      = color_reg.b;
    assign green     = color_reg.g;
    assign red       = color_reg.r;
    assign alpha     = color_reg.a;
    assign run_end   = run_end_reg;

    // A palette write never leaves a pixel in the capture stage.
    a_pal_write_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (opcode == OP_PAL_WRITE) |=> !s1_valid_reg)
        else $error("palette write produced a pixel in the capture stage");

    // An accepted convert always occupies the capture stage next cycle.
    a_convert_captured: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (opcode == OP_CONVERT) |=> s1_valid_reg)
        else $error("accepted convert transaction was lost");

    // A stalled capture stage keeps its pixel.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_bytes_reg)
            && $stable(s1_last_reg))
        else $error("capture stage changed while stalled");

    // Output only becomes valid from a pixel in the capture stage.
    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("output valid without a captured pixel");

endmodule
